// File: rtl/core/swfc_pkg.sv
// ----------------------------------------------------------------------------
// swfc_pkg
// shared constants, types and header builder for the sorted word front coder
// ----------------------------------------------------------------------------
`default_nettype none

package swfc_pkg;

    localparam int BYTE_W       = 8;
    localparam int INDEX_BITS   = 11;
    localparam int VALUE_W      = 16;
    localparam int PREFIX_LIMIT = 15;
    localparam int KEEP_DEPTH   = 15;
    localparam int POS_W        = 4;
    localparam int ADDR_W       = $clog2(KEEP_DEPTH);
    localparam int OQ_DEPTH     = 4;
    localparam int OQ_PTR_W     = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W     = $clog2(OQ_DEPTH + 1);
    localparam int IN_DATA_W    = 24;

    localparam logic [POS_W-1:0]   POS_MAX     = '1;
    localparam logic [VALUE_W-1:0] HEADER_FLAG = 16'h8000;

    // push counts into the output queue
    localparam logic [1:0] PUSH_NONE = 2'd0;
    localparam logic [1:0] PUSH_ONE  = 2'd1;
    localparam logic [1:0] PUSH_TWO  = 2'd2;

    typedef struct packed {
        logic               is_header;
        logic [VALUE_W-1:0] out_value;
        logic               word_done;
    } t_res;

    typedef struct packed {
        logic [1:0] n;
        t_res       r0;
        t_res       r1;
    } t_push;

    typedef struct packed {
        logic [BYTE_W-1:0]     char_byte;
        logic [INDEX_BITS-1:0] affix_index;
        logic                  word_end;
        logic [POS_W-1:0]      pos;
    } t_item;

    function automatic logic [VALUE_W-1:0] make_header(
        input logic [POS_W-1:0]      prefix,
        input logic [INDEX_BITS-1:0] index
    );
        logic [VALUE_W-1:0] h;
        h = HEADER_FLAG
          | (VALUE_W'(prefix) << INDEX_BITS)
          | VALUE_W'(index);
        return h;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/sorted_word_front_coder_top.sv
// ----------------------------------------------------------------------------
// sorted_word_front_coder_top
// front coder for sorted words, one byte per request, header plus suffix out
// ----------------------------------------------------------------------------
//  channel | dir | tdata                             | tuser        | tlast
//  s_axis  | in  | [7:0] char_byte, [18:8] affix_idx | -            | word_end
//  m_axis  | out | [15:0] out_value                  | [0] is_header| word_done
//
//  one input request per cycle; a request reads the ram entry of its byte
//  position on acceptance and is compared and written back from r_item
//  a first mismatch yields two results; the input stalls while the 4-entry
//  result queue lacks room for two results, so output stalls reach the input
//  reset clears position, stored length and queue and sets the match flag;
//  stale ram bytes at or past the stored length never take part in a compare
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_word_front_coder_top
    import swfc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // [7:0] char_byte, [18:8] affix_index, [23:19] zero
    input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
    input  wire logic                 s_axis_tlast,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // [15:0] out_value
    output logic      [VALUE_W-1:0]   m_axis_tdata,
    // [0] is_header
    output logic      [0:0]           m_axis_tuser,
    output logic                      m_axis_tlast,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready
);

    // byte position of the next incoming request
    logic [POS_W-1:0]  r_pos, n_pos;
    // compare stage holding register
    logic              r_v2;
    t_item             r_item;
    // forwarding of a same-entry write that collides with the read
    logic              r_fwd;
    logic [BYTE_W-1:0] r_fwd_data;

    logic              accept;
    logic              fire;
    logic              space;
    logic              we;
    logic              re;
    logic [BYTE_W-1:0] ram_rdata;
    logic [BYTE_W-1:0] ref_byte;
    t_push             push;
    t_res              q_res;

    assign fire          = r_v2 && space;
    assign s_axis_tready = !r_v2 || fire;
    assign accept        = s_axis_tvalid && s_axis_tready;
    // positions past the kept depth never match, so no read is needed there
    assign re            = accept && (r_pos < POS_W'(KEEP_DEPTH));
    assign ref_byte      = r_fwd ? r_fwd_data : ram_rdata;

    always_comb begin
        priority if (!accept) begin
            n_pos = r_pos;
        end else if (s_axis_tlast) begin
            n_pos = '0;
        end else if (r_pos == POS_MAX) begin
            n_pos = POS_MAX;
        end else begin
            n_pos = r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_v2  <= 1'b0;
        end else begin
            r_pos <= n_pos;
            if (accept) begin
                r_v2 <= 1'b1;
            end else if (fire) begin
                r_v2 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.char_byte   <= s_axis_tdata[BYTE_W-1:0];
            r_item.affix_index <= s_axis_tdata[BYTE_W +: INDEX_BITS];
            r_item.word_end    <= s_axis_tlast;
            r_item.pos         <= r_pos;
            // write-back of the item leaving now lands on the entry being read
            r_fwd              <= we && (r_item.pos == r_pos);
            r_fwd_data         <= r_item.char_byte;
        end
    end

    swfc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (KEEP_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_item.pos[ADDR_W-1:0]),
        .i_wdata (r_item.char_byte),
        .i_re    (re),
        .i_raddr (r_pos[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    swfc_cmp u_cmp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_item     (r_item),
        .i_ref_byte (ref_byte),
        .o_push     (push),
        .o_we       (we)
    );

    swfc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_valid (m_axis_tvalid),
        .o_res   (q_res),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata    = q_res.out_value;
    assign m_axis_tuser[0] = q_res.is_header;
    assign m_axis_tlast    = q_res.word_done;

    a_pos_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && s_axis_tlast) |=> r_pos == '0)
        else $error("position not restarted after word end");

    a_write_only_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> fire)
        else $error("ram written without a compare");

    a_fire_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !fire) |=> (r_v2 && $stable(r_item.pos)))
        else $error("stalled compare item lost");

endmodule

`default_nettype wire

// File: rtl/core/swfc_ram.sv
// ----------------------------------------------------------------------------
// swfc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module swfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/swfc_cmp.sv
// ----------------------------------------------------------------------------
// swfc_cmp
// compare stage: matches a byte against the previous word, builds results
// ----------------------------------------------------------------------------
`default_nettype none

module swfc_cmp
    import swfc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire t_item             i_item,
    input  wire logic [BYTE_W-1:0] i_ref_byte,
    output t_push                  o_push,
    output logic                   o_we
);

    logic [POS_W-1:0] r_prev_len, n_prev_len;
    logic             r_matching, n_matching;

    logic             match;
    logic             at_cap;
    logic [POS_W:0]   pos_inc;
    logic [POS_W-1:0] pos_next;
    t_res             hdr_res;
    t_res             byte_res;

    assign pos_inc  = {1'b0, i_item.pos} + 1'b1;
    assign pos_next = (i_item.pos == POS_MAX) ? POS_MAX : pos_inc[POS_W-1:0];
    assign at_cap   = pos_inc >= (POS_W+1)'(PREFIX_LIMIT);
    assign match    = (i_item.pos < r_prev_len)
                    && (i_item.pos < POS_W'(PREFIX_LIMIT))
                    && (i_ref_byte == i_item.char_byte);

    assign byte_res.is_header = 1'b0;
    assign byte_res.out_value = VALUE_W'(i_item.char_byte);
    assign byte_res.word_done = i_item.word_end;

    assign o_we = i_fire && (i_item.pos < POS_W'(KEEP_DEPTH));

    always_comb begin
        o_push     = '0;
        n_matching = r_matching;
        n_prev_len = r_prev_len;
        hdr_res    = '0;
        if (r_matching) begin
            if (match) begin
                if (at_cap || i_item.word_end) begin
                    hdr_res.is_header = 1'b1;
                    hdr_res.out_value = make_header(pos_inc[POS_W-1:0], i_item.affix_index);
                    hdr_res.word_done = i_item.word_end;
                    o_push.n          = PUSH_ONE;
                    o_push.r0         = hdr_res;
                    n_matching        = 1'b0;
                end
            end else begin
                // first mismatch: header with the prefix so far, then this byte
                hdr_res.is_header = 1'b1;
                hdr_res.out_value = make_header(i_item.pos, i_item.affix_index);
                hdr_res.word_done = 1'b0;
                o_push.n          = PUSH_TWO;
                o_push.r0         = hdr_res;
                o_push.r1         = byte_res;
                n_matching        = 1'b0;
            end
        end else begin
            o_push.n  = PUSH_ONE;
            o_push.r0 = byte_res;
        end
        if (i_item.word_end) begin
            n_prev_len = pos_next;
            n_matching = 1'b1;
        end
        if (!i_fire) begin
            o_push.n = PUSH_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_len <= '0;
            r_matching <= 1'b1;
        end else if (i_fire) begin
            r_prev_len <= n_prev_len;
            r_matching <= n_matching;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/swfc_outq.sv
// ----------------------------------------------------------------------------
// swfc_outq
// small result queue: up to two pushes and one pop per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module swfc_outq
    import swfc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    output logic       o_space,
    output logic       o_valid,
    output t_res       o_res,
    input  wire logic  i_ready
);

    t_res                r_q [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wp, r_rp;
    logic [OQ_CNT_W-1:0] r_cnt, n_cnt;
    logic                pop;

    assign o_valid = r_cnt != '0;
    assign o_res   = r_q[r_rp];
    assign pop     = o_valid && i_ready;
    // room for a two-result push
    assign o_space = r_cnt <= OQ_CNT_W'(OQ_DEPTH - 2);
    assign n_cnt   = r_cnt + OQ_CNT_W'(i_push.n) - OQ_CNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (i_push.n != PUSH_NONE) begin
            r_q[r_wp] <= i_push.r0;
        end
        if (i_push.n == PUSH_TWO) begin
            r_q[r_wp + 1'b1] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + OQ_PTR_W'(i_push.n);
            r_rp  <= r_rp + OQ_PTR_W'(pop);
            r_cnt <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= OQ_CNT_W'(OQ_DEPTH))
        else $error("result queue overflow");

    a_push_needs_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.n != PUSH_NONE) |-> o_space)
        else $error("push into a queue without room");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_cnt == $past(n_cnt))
        else $error("queue count mismatch");

endmodule

`default_nettype wire
